/* design/htfc_pkg.sv */
// Shared widths, codes and constants of the humidity/temperature frame checker.
`timescale 1ns / 1ps
package htfc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned RAW_W     = 16;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned VALUE_W   = 15;
  localparam int unsigned SCALE_W   = 15;
  localparam int unsigned PRODUCT_W = RAW_W + SCALE_W;

  // Generator 0x131 without its top term
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

  // Bits 1..0 of the raw value are sensor status, not data
  localparam logic [RAW_W-1:0] RAW_MASK = 16'hFFFC;

  // Fixed-point conversion: floor(scale * r / 65536) - offset
  localparam logic [SCALE_W-1:0] HUMID_SCALE  = 15'd12500;
  localparam logic [SCALE_W-1:0] TEMP_SCALE   = 15'd17572;
  localparam logic [VALUE_W-1:0] HUMID_OFFSET = 15'd600;
  localparam logic [VALUE_W-1:0] TEMP_OFFSET  = 15'd4685;

  localparam logic [COUNT_W-1:0] COUNT_MAX        = 4'd15;
  localparam logic [COUNT_W-1:0] NACK_LIMIT_RESET = 4'd3;

  localparam logic FUNC_NACK  = 1'b0;
  localparam logic FUNC_FRAME = 1'b1;
  localparam logic KIND_HUMID = 1'b0;
  localparam logic KIND_TEMP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CRC     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd2;

endpackage

/* design/htfc_crc.sv */
// CRC-8 (poly 0x131, init zero) check of a two-byte frame against its check byte.
`timescale 1ns / 1ps
module htfc_crc import htfc_pkg::*; (
  input  logic [BYTE_W-1:0] high_byte,
  input  logic [BYTE_W-1:0] low_byte,
  input  logic [BYTE_W-1:0] check_byte,
  output logic              crc_bad
);

  function automatic logic [BYTE_W-1:0] crc_byte(input logic [BYTE_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] data);
    logic [BYTE_W-1:0] crc;
    crc = crc_in ^ data;
    for (int i = 0; i < BYTE_W; i++) begin
      if (crc[BYTE_W-1]) begin
        crc = (crc << 1) ^ CRC_POLY;
      end else begin
        crc = crc << 1;
      end
    end
    return crc;
  endfunction

  logic [BYTE_W-1:0] crc_high;
  logic [BYTE_W-1:0] crc_full;

  assign crc_high = crc_byte('0, high_byte);
  assign crc_full = crc_byte(crc_high, low_byte);
  assign crc_bad  = (crc_full != check_byte);

endmodule

/* design/htfc_conv.sv */
// Raw sensor value to hundredths of a percent or of a degree.
`timescale 1ns / 1ps
module htfc_conv import htfc_pkg::*; (
  input  logic               kind,
  input  logic [RAW_W-1:0]   raw,
  output logic [VALUE_W-1:0] value_centi
);

  logic [SCALE_W-1:0]   scale;
  logic [VALUE_W-1:0]   offset;
  logic [PRODUCT_W-1:0] product;
  logic [VALUE_W:0]     diff;

  assign scale   = (kind == KIND_TEMP) ? TEMP_SCALE : HUMID_SCALE;
  assign offset  = (kind == KIND_TEMP) ? TEMP_OFFSET : HUMID_OFFSET;
  assign product = PRODUCT_W'(raw & RAW_MASK) * PRODUCT_W'(scale);
  // Floor of product / 65536 is the upper bits; always below 2^15
  assign diff        = {1'b0, product[PRODUCT_W-1:RAW_W]} - {1'b0, offset};
  assign value_centi = diff[VALUE_W-1:0];

endmodule

/* design/humidity_temp_frame_checker_core.sv */
// Humidity/temperature frame checker: CRC check, conversion and NACK timeout.
// An input transfer is held in the input register; its result goes out from the result register.
// Throughput: one item per cycle unless the output stalls; an input register feeds one layer
//   of CRC, constant-multiply and NACK-count logic that loads the result register.
// Reset (rst, synchronous, active high): clears both NACK counts, empties both
//   registers and loads nack_limit with 3. No clearing pass is needed.
`timescale 1ns / 1ps
module humidity_temp_frame_checker_core import htfc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // high_byte[7:0], low_byte[15:8], check_byte[23:16]
  input  logic [1:0]          s_axis_tuser,   // func[0], kind[1]
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata,   // value_centi[14:0], zero pad[15]
  output logic [2:0]          m_axis_tuser,   // status[1:0], result_kind[2]
  // Configuration write channel: nack_limit
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_data
);

  // Configuration register; writes are always taken
  logic [COUNT_W-1:0] nack_limit;

  // Input register
  logic              in_valid;
  logic              in_func;
  logic              in_kind;
  logic [BYTE_W-1:0] in_high;
  logic [BYTE_W-1:0] in_low;
  logic [BYTE_W-1:0] in_check;

  // Per-kind NACK counts
  logic [COUNT_W-1:0] humid_nack_count;
  logic [COUNT_W-1:0] temp_nack_count;

  // Result register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic                out_kind;
  logic [VALUE_W-1:0]  out_value;

  logic                advance;
  logic                crc_bad;
  logic [VALUE_W-1:0]  conv_value;
  logic [COUNT_W-1:0]  count_cur;
  logic [COUNT_W-1:0]  count_bumped;
  logic [COUNT_W-1:0]  count_next;
  logic                timeout;
  logic                produce;
  logic [STATUS_W-1:0] status_next;
  logic [VALUE_W-1:0]  value_next;

  htfc_crc u_crc (
    .high_byte  (in_high),
    .low_byte   (in_low),
    .check_byte (in_check),
    .crc_bad    (crc_bad)
  );

  htfc_conv u_conv (
    .kind        (in_kind),
    .raw         ({in_high, in_low}),
    .value_centi (conv_value)
  );

  // The held item moves on whenever the result register is free or being drained.
  // An item that yields no result still waits for that slot, which keeps the
  // control to a single condition.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  // NACK counting: bump (saturating) on a NACK, then a count above the limit
  // forces a timeout and clears, even when the item is a frame.
  always_comb begin
    count_cur = (in_kind == KIND_TEMP) ? temp_nack_count : humid_nack_count;
    if (in_func == FUNC_NACK && count_cur != COUNT_MAX) begin
      count_bumped = count_cur + 1'b1;
    end else begin
      count_bumped = count_cur;
    end
    timeout    = (count_bumped > nack_limit);
    count_next = timeout ? '0 : count_bumped;
    produce    = timeout || (in_func == FUNC_FRAME);

    if (timeout) begin
      status_next = STATUS_TIMEOUT;
    end else if (crc_bad) begin
      status_next = STATUS_CRC;
    end else begin
      status_next = STATUS_OK;
    end
    value_next = (status_next == STATUS_OK) ? conv_value : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nack_limit <= NACK_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      nack_limit <= cfg_data;
    end
  end

  // Input register: load on a transfer, drop once the item has advanced
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func  <= s_axis_tuser[0];
      in_kind  <= s_axis_tuser[1];
      in_high  <= s_axis_tdata[7:0];
      in_low   <= s_axis_tdata[15:8];
      in_check <= s_axis_tdata[23:16];
    end
  end

  // Counts change only when the item is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      humid_nack_count <= '0;
      temp_nack_count  <= '0;
    end else if (advance) begin
      if (in_kind == KIND_TEMP) begin
        temp_nack_count <= count_next;
      end else begin
        humid_nack_count <= count_next;
      end
    end
  end

  // Result register: load on advance, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= produce;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= status_next;
      out_kind   <= in_kind;
      out_value  <= value_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_value};
  assign m_axis_tuser  = {out_kind, out_status};

endmodule
